// ----- rtl/bmm_pkg.sv -----
// Shared types and constants for the blocked matrix multiply.
// Holds the item structs, request and register codes, and the microcode ROM.
// No dependencies.
package bmm_pkg;

  localparam int OUT_BITS = 36;
  localparam int CFG_BITS = 5;
  localparam int CFG_IDX_BITS = 1;
  localparam int UPC_BITS = 5;

  localparam logic [CFG_BITS-1:0] CFG_SIZE_RST = 5'd16;
  localparam logic [CFG_BITS-1:0] CFG_TILE_RST = 5'd4;

  localparam logic [CFG_IDX_BITS-1:0] CFG_MATRIX_SIZE = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TILE_SIZE   = 1'd1;

  typedef enum logic [1:0] {
    REQ_LOAD_A  = 2'd0,
    REQ_LOAD_B  = 2'd1,
    REQ_COMPUTE = 2'd2,
    REQ_READ_C  = 2'd3
  } req_type_t;

  typedef struct packed {
    req_type_t          req_type;
    logic [3:0]         row;
    logic [3:0]         col;
    logic signed [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic [3:0]                 row_res;
    logic [3:0]                 col_res;
    logic signed [OUT_BITS-1:0] product_value;
  } out_item_t;

  // microcode step addresses; the reset clear falls through into idle
  typedef enum logic [UPC_BITS-1:0] {
    U_RCLR, U_IDLE, U_CLR, U_PINIT, U_PCNT, U_TI0, U_TJ0, U_EI0, U_EJ0, U_KINIT,
    U_SB, U_MAC, U_KSTEP, U_DRAIN, U_CWR, U_JSTEP, U_ISTEP, U_TJSTEP,
    U_TISTEP, U_DONE
  } upc_t;

  // datapath actions
  typedef enum logic [4:0] {
    A_NONE, A_IDLE, A_CLEAR, A_INIT, A_PSTEP, A_TI_INIT, A_TJ_INIT,
    A_EI_INIT, A_EJ_INIT, A_K_INIT, A_SB_SET, A_MAC, A_K_STEP, A_C_WRITE,
    A_J_STEP, A_I_STEP, A_TJ_STEP, A_TI_STEP
  } act_t;

  // jump conditions: jump to target when true, else fall through
  typedef enum logic [3:0] {
    C_NEVER, C_ALWAYS, C_NO_CMD, C_CLR_MORE, C_P_MORE, C_M_MORE, C_K_MORE,
    C_J_MORE, C_I_MORE, C_TJ_MORE, C_TI_MORE
  } cond_t;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    upc_t  target;
  } uword_t;

  function automatic uword_t ucode(input upc_t pc);
    uword_t w;
    case (pc)
      U_RCLR:   w = '{act: A_CLEAR,   cond: C_CLR_MORE, target: U_RCLR};
      U_IDLE:   w = '{act: A_IDLE,    cond: C_NO_CMD,   target: U_IDLE};
      U_CLR:    w = '{act: A_CLEAR,   cond: C_CLR_MORE, target: U_CLR};
      U_PINIT:  w = '{act: A_INIT,    cond: C_NEVER,    target: U_IDLE};
      U_PCNT:   w = '{act: A_PSTEP,   cond: C_P_MORE,   target: U_PCNT};
      U_TI0:    w = '{act: A_TI_INIT, cond: C_NEVER,    target: U_IDLE};
      U_TJ0:    w = '{act: A_TJ_INIT, cond: C_NEVER,    target: U_IDLE};
      U_EI0:    w = '{act: A_EI_INIT, cond: C_NEVER,    target: U_IDLE};
      U_EJ0:    w = '{act: A_EJ_INIT, cond: C_NEVER,    target: U_IDLE};
      U_KINIT:  w = '{act: A_K_INIT,  cond: C_NEVER,    target: U_IDLE};
      U_SB:     w = '{act: A_SB_SET,  cond: C_NEVER,    target: U_IDLE};
      U_MAC:    w = '{act: A_MAC,     cond: C_M_MORE,   target: U_MAC};
      U_KSTEP:  w = '{act: A_K_STEP,  cond: C_K_MORE,   target: U_SB};
      U_DRAIN:  w = '{act: A_NONE,    cond: C_NEVER,    target: U_IDLE};
      U_CWR:    w = '{act: A_C_WRITE, cond: C_NEVER,    target: U_IDLE};
      U_JSTEP:  w = '{act: A_J_STEP,  cond: C_J_MORE,   target: U_KINIT};
      U_ISTEP:  w = '{act: A_I_STEP,  cond: C_I_MORE,   target: U_EJ0};
      U_TJSTEP: w = '{act: A_TJ_STEP, cond: C_TJ_MORE,  target: U_EI0};
      U_TISTEP: w = '{act: A_TI_STEP, cond: C_TI_MORE,  target: U_TJ0};
      U_DONE:   w = '{act: A_NONE,    cond: C_ALWAYS,   target: U_IDLE};
      default:  w = '{act: A_NONE,    cond: C_ALWAYS,   target: U_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/bmm_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the A, B and C matrix stores. No dependencies.
module bmm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/blocked_matrix_multiply.sv -----
// Blocked matrix multiply: loads A and B, computes C = A*B by tiles, reads C.
// Loads and reads take one item per cycle while not busy; a read's item is on out_valid in the next cycle.
// A compute holds busy while it clears C and then multiplies by tiles (p tiles of edge q),
// one MAC issue per cycle through one multiplier.
// Synchronous active-low reset sets sizes to 16/4 and clears C, holding busy meanwhile.
// Results cannot be stalled. Depends on bmm_pkg and bmm_ram.
module blocked_matrix_multiply #(
  parameter int MAX_DIM   = 16,
  parameter int ELEM_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  bmm_pkg::in_item_t                   in_item,
  output logic                                out_valid,
  output bmm_pkg::out_item_t                  out_item,
  input  logic                                cfg_we,
  input  logic [bmm_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [bmm_pkg::CFG_BITS-1:0]        cfg_data
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CW    = $clog2(MAX_DIM + 1);
  localparam int SW    = CW + 1;
  localparam int OB    = bmm_pkg::OUT_BITS;
  localparam int PW    = 2 * ELEM_BITS;

  function automatic logic [AW-1:0] cell_addr(input logic [IW-1:0] r,
                                              input logic [IW-1:0] c);
    return AW'(r) * AW'(MAX_DIM) + AW'(c);
  endfunction

  // configuration
  logic [bmm_pkg::CFG_BITS-1:0] size_r, size_nxt, tile_r, tile_nxt;

  // sequencer
  bmm_pkg::upc_t   upc_r, upc_nxt;
  bmm_pkg::uword_t uw;
  logic            jump;

  // loop registers
  logic [CW-1:0] n_r, n_nxt, q_r, q_nxt, p_r, p_nxt;
  logic [SW-1:0] pb_r, pb_nxt;
  logic [CW-1:0] ti_r, ti_nxt, tj_r, tj_nxt, rb_r, rb_nxt, cb_r, cb_nxt;
  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt, m_r, m_nxt;
  logic [CW-1:0] kt_r, kt_nxt, sb_r, sb_nxt;
  logic [AW-1:0] ca_r, ca_nxt;
  logic [OB-1:0] acc_r, acc_nxt;
  logic signed [PW-1:0] prod_r;
  logic          v1_r, v1_nxt, v2_r;

  // host side
  logic          accept, in_range;
  logic [IW-1:0] h_row, h_col;
  logic [ELEM_BITS-1:0] elem;
  logic          rd_pend_r, rd_in_r;
  logic [3:0]    rd_row_r, rd_col_r;

  // derived indexes
  logic [SW-1:0] r_cur, c_cur, s_cur, tt_sum, kt_inc;
  logic [2*CW-1:0] sb_prod;
  logic [CW-1:0] n_clamp;
  logic          s_ok;

  // memory ports
  logic                 a_we, b_we, c_we;
  logic [AW-1:0]        ab_waddr, a_raddr, b_raddr, c_waddr, c_raddr;
  logic [ELEM_BITS-1:0] a_rdata, b_rdata;
  logic [OB-1:0]        c_wdata, c_rdata;

  assign busy     = (upc_r != bmm_pkg::U_IDLE);
  assign accept   = start && !busy;
  assign in_range = (int'(in_item.row) < MAX_DIM) && (int'(in_item.col) < MAX_DIM);
  assign h_row    = IW'(in_item.row);
  assign h_col    = IW'(in_item.col);
  assign elem     = ELEM_BITS'(in_item.value);

  assign r_cur   = SW'(rb_r) + SW'(i_r);
  assign c_cur   = SW'(cb_r) + SW'(j_r);
  assign s_cur   = SW'(sb_r) + SW'(m_r);
  assign s_ok    = (s_cur < SW'(n_r));
  assign tt_sum  = SW'(ti_r) + SW'(tj_r);
  assign kt_inc  = SW'(kt_r) + SW'(1);
  assign sb_prod = kt_r * q_r;

  // config register writes
  always_comb begin
    size_nxt = size_r;
    tile_nxt = tile_r;
    if (cfg_we) begin
      case (cfg_index)
        bmm_pkg::CFG_MATRIX_SIZE: size_nxt = cfg_data;
        bmm_pkg::CFG_TILE_SIZE:   tile_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  // next step: jump or fall through
  always_comb begin
    uw = bmm_pkg::ucode(upc_r);
    case (uw.cond)
      bmm_pkg::C_NEVER:    jump = 1'b0;
      bmm_pkg::C_ALWAYS:   jump = 1'b1;
      bmm_pkg::C_NO_CMD:   jump = !(accept && in_item.req_type == bmm_pkg::REQ_COMPUTE);
      bmm_pkg::C_CLR_MORE: jump = (ca_r != AW'(DEPTH - 1));
      bmm_pkg::C_P_MORE:   jump = (pb_r + SW'(q_r) < SW'(n_r));
      bmm_pkg::C_M_MORE:   jump = (SW'(m_r) + SW'(1) < SW'(q_r));
      bmm_pkg::C_K_MORE:   jump = (SW'(k_r) + SW'(1) < SW'(p_r));
      bmm_pkg::C_J_MORE:   jump = (SW'(j_r) + SW'(1) < SW'(q_r)) &&
                                  (c_cur + SW'(1) < SW'(n_r));
      bmm_pkg::C_I_MORE:   jump = (SW'(i_r) + SW'(1) < SW'(q_r)) &&
                                  (r_cur + SW'(1) < SW'(n_r));
      bmm_pkg::C_TJ_MORE:  jump = (SW'(cb_r) + SW'(q_r) < SW'(n_r));
      bmm_pkg::C_TI_MORE:  jump = (SW'(rb_r) + SW'(q_r) < SW'(n_r));
      default:             jump = 1'b0;
    endcase
    upc_nxt = jump ? uw.target : bmm_pkg::upc_t'(upc_r + 1'b1);
  end

  // datapath controlled by the current control word
  always_comb begin
    n_nxt  = n_r;   q_nxt  = q_r;   p_nxt  = p_r;   pb_nxt = pb_r;
    ti_nxt = ti_r;  tj_nxt = tj_r;  rb_nxt = rb_r;  cb_nxt = cb_r;
    i_nxt  = i_r;   j_nxt  = j_r;   k_nxt  = k_r;   m_nxt  = m_r;
    kt_nxt = kt_r;  sb_nxt = sb_r;  ca_nxt = ca_r;
    acc_nxt = v2_r ? acc_r + OB'(prod_r) : acc_r;
    v1_nxt  = 1'b0;
    c_we    = 1'b0;
    c_waddr = ca_r;
    c_wdata = '0;
    n_clamp = CW'(MAX_DIM);
    if (size_r == '0) begin
      n_clamp = CW'(1);
    end else if (int'(size_r) <= MAX_DIM) begin
      n_clamp = CW'(size_r);
    end
    case (uw.act)
      bmm_pkg::A_IDLE:    ca_nxt = '0;
      bmm_pkg::A_CLEAR: begin
        c_we   = 1'b1;
        ca_nxt = ca_r + AW'(1);
      end
      bmm_pkg::A_INIT: begin
        n_nxt = n_clamp;
        if (tile_r == '0) begin
          q_nxt = CW'(1);
        end else if (int'(tile_r) > int'(n_clamp)) begin
          q_nxt = n_clamp;
        end else begin
          q_nxt = CW'(tile_r);
        end
        p_nxt  = '0;
        pb_nxt = '0;
      end
      bmm_pkg::A_PSTEP: begin
        pb_nxt = pb_r + SW'(q_r);
        p_nxt  = p_r + CW'(1);
      end
      bmm_pkg::A_TI_INIT: begin
        ti_nxt = '0;
        rb_nxt = '0;
      end
      bmm_pkg::A_TJ_INIT: begin
        tj_nxt = '0;
        cb_nxt = '0;
      end
      bmm_pkg::A_EI_INIT: i_nxt = '0;
      bmm_pkg::A_EJ_INIT: j_nxt = '0;
      bmm_pkg::A_K_INIT: begin
        acc_nxt = '0;
        k_nxt   = '0;
        // Cannon skew: first tile step is (I+J) mod p
        kt_nxt  = (tt_sum >= SW'(p_r)) ? CW'(tt_sum - SW'(p_r)) : CW'(tt_sum);
      end
      bmm_pkg::A_SB_SET: begin
        sb_nxt = CW'(sb_prod);
        m_nxt  = '0;
      end
      bmm_pkg::A_MAC: begin
        v1_nxt = s_ok;
        m_nxt  = m_r + CW'(1);
      end
      bmm_pkg::A_K_STEP: begin
        k_nxt  = k_r + CW'(1);
        kt_nxt = (kt_inc == SW'(p_r)) ? '0 : CW'(kt_inc);
      end
      bmm_pkg::A_C_WRITE: begin
        c_we    = 1'b1;
        c_waddr = cell_addr(IW'(r_cur), IW'(c_cur));
        c_wdata = acc_r;
      end
      bmm_pkg::A_J_STEP:  j_nxt = j_r + CW'(1);
      bmm_pkg::A_I_STEP:  i_nxt = i_r + CW'(1);
      bmm_pkg::A_TJ_STEP: begin
        tj_nxt = tj_r + CW'(1);
        cb_nxt = CW'(SW'(cb_r) + SW'(q_r));
      end
      bmm_pkg::A_TI_STEP: begin
        ti_nxt = ti_r + CW'(1);
        rb_nxt = CW'(SW'(rb_r) + SW'(q_r));
      end
      default: ;
    endcase
  end

  assign ab_waddr = cell_addr(h_row, h_col);
  assign a_we     = accept && in_range && (in_item.req_type == bmm_pkg::REQ_LOAD_A);
  assign b_we     = accept && in_range && (in_item.req_type == bmm_pkg::REQ_LOAD_B);
  assign a_raddr  = cell_addr(IW'(r_cur), IW'(s_cur));
  assign b_raddr  = cell_addr(IW'(s_cur), IW'(c_cur));
  assign c_raddr  = cell_addr(h_row, h_col);

  bmm_ram #(.WIDTH(ELEM_BITS), .DEPTH(DEPTH)) u_ram_a (
    .clk(clk), .we(a_we), .waddr(ab_waddr), .wdata(elem),
    .raddr(a_raddr), .rdata(a_rdata)
  );

  bmm_ram #(.WIDTH(ELEM_BITS), .DEPTH(DEPTH)) u_ram_b (
    .clk(clk), .we(b_we), .waddr(ab_waddr), .wdata(elem),
    .raddr(b_raddr), .rdata(b_rdata)
  );

  bmm_ram #(.WIDTH(OB), .DEPTH(DEPTH)) u_ram_c (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .raddr(c_raddr), .rdata(c_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r     <= bmm_pkg::U_RCLR;
      ca_r      <= '0;
      size_r    <= bmm_pkg::CFG_SIZE_RST;
      tile_r    <= bmm_pkg::CFG_TILE_RST;
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      rd_pend_r <= 1'b0;
    end else begin
      upc_r     <= upc_nxt;
      ca_r      <= ca_nxt;
      size_r    <= size_nxt;
      tile_r    <= tile_nxt;
      v1_r      <= v1_nxt;
      v2_r      <= v1_r;
      rd_pend_r <= accept && (in_item.req_type == bmm_pkg::REQ_READ_C);
    end
  end

  always_ff @(posedge clk) begin
    n_r  <= n_nxt;   q_r  <= q_nxt;   p_r  <= p_nxt;   pb_r <= pb_nxt;
    ti_r <= ti_nxt;  tj_r <= tj_nxt;  rb_r <= rb_nxt;  cb_r <= cb_nxt;
    i_r  <= i_nxt;   j_r  <= j_nxt;   k_r  <= k_nxt;   m_r  <= m_nxt;
    kt_r <= kt_nxt;  sb_r <= sb_nxt;  acc_r <= acc_nxt;
    prod_r   <= $signed(a_rdata) * $signed(b_rdata);
    rd_in_r  <= in_range;
    rd_row_r <= in_item.row;
    rd_col_r <= in_item.col;
  end

  assign out_valid              = rd_pend_r;
  assign out_item.row_res       = rd_row_r;
  assign out_item.col_res       = rd_col_r;
  assign out_item.product_value = rd_in_r ? c_rdata : '0;

  // a result item only follows an accepted read
  a_out_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && in_item.req_type == bmm_pkg::REQ_READ_C))
    else $error("result item without a read request");

  // the sequencer leaves idle only on a compute request
  a_busy_from_compute: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start && in_item.req_type == bmm_pkg::REQ_COMPUTE))
    else $error("sequencer started without a compute request");

  // product writes stay inside the n x n region
  a_cwr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (upc_r == bmm_pkg::U_CWR) |-> (r_cur < SW'(n_r) && c_cur < SW'(n_r)))
    else $error("C write outside the active matrix");

  // MAC pipeline only fills from the issue step
  a_mac_issue: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |=> $past(upc_r == bmm_pkg::U_MAC, 2))
    else $error("MAC valid without an issue step");

endmodule

// ----- bench/tb_blocked_matrix_multiply.sv -----
`timescale 1ns / 100ps
// Testbench for blocked_matrix_multiply: loads A and B, runs products, checks C reads.
// A scoreboard class predicts every C element exactly; plain tasks drive the block.
// Depends on bmm_pkg and the blocked_matrix_multiply RTL.
module tb_blocked_matrix_multiply;

  localparam int DIM         = 16;
  localparam int ITEM_TARGET = 1600;
  // slowest compute: clears C, then sequences size 16 at tile edge 1
  localparam int STALL_LIMIT = 60000;

  typedef enum int {FILL_RANDOM, FILL_EXTREME, FILL_MIN, FILL_SMALL} fill_t;

  class product_scoreboard;
    logic signed [15:0]                  a_mem [DIM][DIM];
    logic signed [15:0]                  b_mem [DIM][DIM];
    logic signed [bmm_pkg::OUT_BITS-1:0] c_mem [DIM][DIM];
    logic [bmm_pkg::CFG_BITS-1:0]        size_reg;
    logic [bmm_pkg::CFG_BITS-1:0]        tile_reg;
    bmm_pkg::out_item_t                  expected_q[$];
    int                                  mismatches;
    int                                  reads_checked;
    int                                  products_formed;

    function void clear();
      foreach (c_mem[r, c]) begin
        a_mem[r][c] = '0;
        b_mem[r][c] = '0;
        c_mem[r][c] = '0;
      end
      size_reg = bmm_pkg::CFG_SIZE_RST;
      tile_reg = bmm_pkg::CFG_TILE_RST;
    endfunction

    function void write_register(logic [bmm_pkg::CFG_IDX_BITS-1:0] idx,
                                 logic [bmm_pkg::CFG_BITS-1:0] data);
      case (idx)
        bmm_pkg::CFG_MATRIX_SIZE: size_reg = data;
        bmm_pkg::CFG_TILE_SIZE:   tile_reg = data;
        default: ;
      endcase
    endfunction

    // Sums are exact, so the tile order and edge never change C.
    function void form_product();
      int     n;
      longint acc;
      n = (size_reg < 1) ? 1 : ((size_reg > DIM) ? DIM : int'(size_reg));
      foreach (c_mem[r, c]) c_mem[r][c] = '0;
      for (int r = 0; r < n; r++) begin
        for (int c = 0; c < n; c++) begin
          acc = 0;
          for (int s = 0; s < n; s++) acc += longint'(a_mem[r][s]) * longint'(b_mem[s][c]);
          c_mem[r][c] = acc[bmm_pkg::OUT_BITS-1:0];
        end
      end
      products_formed++;
    endfunction

    function void note_input(bmm_pkg::in_item_t it);
      bmm_pkg::out_item_t e;
      case (it.req_type)
        bmm_pkg::REQ_LOAD_A:  a_mem[it.row][it.col] = it.value;
        bmm_pkg::REQ_LOAD_B:  b_mem[it.row][it.col] = it.value;
        bmm_pkg::REQ_COMPUTE: form_product();
        default: begin
          e.row_res       = it.row;
          e.col_res       = it.col;
          e.product_value = c_mem[it.row][it.col];
          expected_q.push_back(e);
        end
      endcase
    endfunction

    task flag_mismatch(string msg);
      $display("mismatch: %s", msg);
      mismatches++;
    endtask

    task check_result(bmm_pkg::out_item_t got);
      bmm_pkg::out_item_t e;
      if (expected_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected C item row %0d col %0d value %0d",
                                got.row_res, got.col_res, got.product_value));
      end else begin
        e = expected_q.pop_front();
        reads_checked++;
        if (got.row_res !== e.row_res)
          flag_mismatch($sformatf("row_res got %0d want %0d", got.row_res, e.row_res));
        if (got.col_res !== e.col_res)
          flag_mismatch($sformatf("col_res got %0d want %0d", got.col_res, e.col_res));
        if (got.product_value !== e.product_value)
          flag_mismatch($sformatf("C(%0d,%0d) got %0d want %0d", e.row_res, e.col_res,
                                  got.product_value, e.product_value));
      end
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                             clk;
  logic                             rst_n;
  logic                             start;
  logic                             busy;
  bmm_pkg::in_item_t                in_item;
  logic                             out_valid;
  bmm_pkg::out_item_t               out_item;
  logic                             cfg_we;
  logic [bmm_pkg::CFG_IDX_BITS-1:0] cfg_index;
  logic [bmm_pkg::CFG_BITS-1:0]     cfg_data;

  product_scoreboard sb;
  bit                a_written [DIM][DIM];
  bit                b_written [DIM][DIM];
  bit                idle_on;
  int                items_sent;
  int                reg_writes;
  int                stall_cycles;

  blocked_matrix_multiply u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // check results and watch for a hung block
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_result(out_item);
      if ((start && !busy) || out_valid) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout: no item accepted for %0d cycles", STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  function automatic bmm_pkg::in_item_t make_item(bmm_pkg::req_type_t kind, int r, int c,
                                                  logic [15:0] v);
    bmm_pkg::in_item_t it;
    it.req_type = kind;
    it.row      = r[3:0];
    it.col      = c[3:0];
    it.value    = v;
    return it;
  endfunction

  function automatic logic [15:0] fill_value(fill_t fill);
    int tmp;
    case (fill)
      FILL_RANDOM: tmp = int'($urandom);
      FILL_MIN:    tmp = 16'h8000;
      FILL_EXTREME: begin
        case ($urandom_range(0, 4))
          0:       tmp = 16'h8000;
          1:       tmp = 16'h7fff;
          2:       tmp = 0;
          3:       tmp = 16'hffff;
          default: tmp = 1;
        endcase
      end
      default:     tmp = int'($urandom_range(0, 1023)) - 512;
    endcase
    return tmp[15:0];
  endfunction

  task automatic send(input bmm_pkg::in_item_t it);
    int gap;
    gap = idle_on ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    sb.note_input(it);
    items_sent++;
  endtask

  task automatic put_elem(input bmm_pkg::req_type_t kind, input int r, input int c,
                          input logic [15:0] v);
    send(make_item(kind, r, c, v));
    if (kind == bmm_pkg::REQ_LOAD_A) a_written[r][c] = 1'b1;
    else b_written[r][c] = 1'b1;
  endtask

  // Write only once the block is quiet: no read outstanding and no compute running.
  task automatic set_register(input logic [bmm_pkg::CFG_IDX_BITS-1:0] idx,
                              input logic [bmm_pkg::CFG_BITS-1:0] data);
    start <= 1'b0;
    repeat (3) @(posedge clk);
    while (busy || sb.pending() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    sb.write_register(idx, data);
    reg_writes++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input int n_raw, input int q_raw, input fill_t fill);
    int                 eff;
    int                 r;
    int                 c;
    bmm_pkg::req_type_t kind;
    eff = (n_raw < 1) ? 1 : ((n_raw > DIM) ? DIM : n_raw);
    set_register(bmm_pkg::CFG_MATRIX_SIZE, n_raw[bmm_pkg::CFG_BITS-1:0]);
    set_register(bmm_pkg::CFG_TILE_SIZE, q_raw[bmm_pkg::CFG_BITS-1:0]);
    idle_on = ($urandom_range(0, 3) != 0);
    // reads of the previous product before anything changes
    repeat ($urandom_range(0, 2))
      send(make_item(bmm_pkg::REQ_READ_C, $urandom_range(0, 15), $urandom_range(0, 15),
                     16'($urandom)));
    // large sizes only fill cells never written, plus some rewrites
    for (int i = 0; i < eff; i++) begin
      for (int j = 0; j < eff; j++) begin
        if (eff <= 8 || !a_written[i][j])
          put_elem(bmm_pkg::REQ_LOAD_A, i, j, fill_value(fill));
        if (eff <= 8 || !b_written[i][j])
          put_elem(bmm_pkg::REQ_LOAD_B, i, j, fill_value(fill));
      end
    end
    if (eff > 8) begin
      repeat (20) begin
        kind = $urandom_range(0, 1) ? bmm_pkg::REQ_LOAD_B : bmm_pkg::REQ_LOAD_A;
        put_elem(kind, $urandom_range(0, eff - 1), $urandom_range(0, eff - 1),
                 fill_value(fill));
      end
    end
    repeat ($urandom_range(0, 3)) begin
      kind = $urandom_range(0, 1) ? bmm_pkg::REQ_LOAD_B : bmm_pkg::REQ_LOAD_A;
      put_elem(kind, $urandom_range(0, 15), $urandom_range(0, 15), 16'($urandom));
    end
    // now and then skip the compute or run it twice
    if ($urandom_range(0, 9) != 0) send(make_item(bmm_pkg::REQ_COMPUTE, 0, 0, 16'h0000));
    if ($urandom_range(0, 7) == 0)
      send(make_item(bmm_pkg::REQ_COMPUTE, $urandom_range(0, 15), $urandom_range(0, 15),
                     16'($urandom)));
    repeat ($urandom_range(3, 2 * eff + 3)) begin
      if ($urandom_range(0, 4) != 0) begin
        r = $urandom_range(0, eff - 1);
        c = $urandom_range(0, eff - 1);
      end else begin
        r = $urandom_range(0, 15);
        c = $urandom_range(0, 15);
      end
      send(make_item(bmm_pkg::REQ_READ_C, r, c, 16'($urandom)));
    end
    // trailing noise; every cell inside the current size is written by now
    repeat ($urandom_range(0, 3)) begin
      kind = bmm_pkg::req_type_t'($urandom_range(0, 3));
      if (kind == bmm_pkg::REQ_LOAD_A || kind == bmm_pkg::REQ_LOAD_B)
        put_elem(kind, $urandom_range(0, 15), $urandom_range(0, 15), 16'($urandom));
      else
        send(make_item(kind, $urandom_range(0, 15), $urandom_range(0, 15),
                       16'($urandom)));
    end
  endtask

  initial begin
    logic [15:0] a_vals [4];
    logic [15:0] b_vals [4];
    int          n_raw;
    int          q_raw;
    int          eff;
    a_vals = '{16'h7fff, 16'h8000, 16'h0001, 16'hffff};
    b_vals = '{16'h8000, 16'h7fff, 16'hffff, 16'h0001};
    sb = new;
    sb.clear();
    stall_cycles = 0;
    items_sent   = 0;
    reg_writes   = 0;
    idle_on      = 1'b1;
    start     <= 1'b0;
    in_item   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    rst_n     <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: read before any compute, then 1x1 and 2x2 products at the extremes
    send(make_item(bmm_pkg::REQ_READ_C, 5, 3, 16'h0000));
    set_register(bmm_pkg::CFG_MATRIX_SIZE, 5'd1);
    set_register(bmm_pkg::CFG_TILE_SIZE, 5'd1);
    put_elem(bmm_pkg::REQ_LOAD_A, 0, 0, 16'h8000);
    put_elem(bmm_pkg::REQ_LOAD_B, 0, 0, 16'h8000);
    put_elem(bmm_pkg::REQ_LOAD_A, 15, 15, 16'h7fff);
    put_elem(bmm_pkg::REQ_LOAD_B, 15, 0, 16'hffff);
    send(make_item(bmm_pkg::REQ_COMPUTE, 0, 0, 16'h0000));
    send(make_item(bmm_pkg::REQ_READ_C, 0, 0, 16'h0000));
    send(make_item(bmm_pkg::REQ_READ_C, 15, 15, 16'hffff));
    set_register(bmm_pkg::CFG_MATRIX_SIZE, 5'd2);
    set_register(bmm_pkg::CFG_TILE_SIZE, 5'd0);
    for (int i = 0; i < 4; i++) begin
      put_elem(bmm_pkg::REQ_LOAD_A, i / 2, i % 2, a_vals[i]);
      put_elem(bmm_pkg::REQ_LOAD_B, i / 2, i % 2, b_vals[i]);
    end
    send(make_item(bmm_pkg::REQ_COMPUTE, 0, 0, 16'h0000));
    send(make_item(bmm_pkg::REQ_COMPUTE, 15, 15, 16'hffff));
    for (int i = 0; i < 4; i++)
      send(make_item(bmm_pkg::REQ_READ_C, i / 2, i % 2, 16'h0000));
    send(make_item(bmm_pkg::REQ_READ_C, 0, 2, 16'h0000));

    // forced corners: full size at the smallest tile, out-of-range register values
    run_phase(16, 1, FILL_MIN);
    run_phase(31, 31, FILL_EXTREME);
    run_phase(0, 0, FILL_RANDOM);
    run_phase(16, 16, FILL_EXTREME);
    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: eff = $urandom_range(1, 6);
        7, 8:                eff = $urandom_range(7, 12);
        default:             eff = $urandom_range(13, 16);
      endcase
      n_raw = eff;
      if (eff == 1 && $urandom_range(0, 1)) n_raw = 0;
      if (eff == DIM && $urandom_range(0, 1)) n_raw = $urandom_range(17, 31);
      q_raw = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(1, eff);
      run_phase(n_raw, q_raw, fill_t'($urandom_range(0, 3)));
    end

    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (sb.pending() != 0)
      sb.flag_mismatch($sformatf("%0d C reads never answered", sb.pending()));
    $display("covered %0d items, %0d register writes, %0d products formed",
             items_sent, reg_writes, sb.products_formed);
    $display("checked %0d C reads, %0d mismatches", sb.reads_checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- blocked_matrix_multiply.f -----
rtl/bmm_pkg.sv
rtl/bmm_ram.sv
rtl/blocked_matrix_multiply.sv
bench/tb_blocked_matrix_multiply.sv
